>>> rtl/utf8v_pkg.sv
package utf8v_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int REPORT_BITS = 16;

    localparam logic [7:0] CONT_LO = 8'h80;
    localparam logic [7:0] CONT_HI = 8'hBF;

    localparam logic [2:0] LEAD2_TAG = 3'h6;
    localparam logic [3:0] LEAD3_TAG = 4'hE;
    localparam logic [4:0] LEAD4_TAG = 5'h1E;
    localparam logic [5:0] LEAD5_TAG = 6'h3E;
    localparam logic [6:0] LEAD6_TAG = 7'h7E;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic                   text_valid;
        logic [REPORT_BITS-1:0] error_offset;
        logic [7:0]             error_lead;
        logic [7:0]             error_follow;
    } t_out_item;

    typedef struct packed {
        logic       bad;
        logic [2:0] cont;
    } t_lead_info;

    function automatic t_lead_info lead_class(input logic [7:0] b);
        t_lead_info info;
        info = '{bad: 1'b0, cont: 3'd0};
        if (b[7] == 1'b0) begin
            info.cont = 3'd0;
        end else if (b[7:5] == LEAD2_TAG) begin
            info.cont = 3'd1;
        end else if (b[7:4] == LEAD3_TAG) begin
            info.cont = 3'd2;
        end else if (b[7:3] == LEAD4_TAG) begin
            info.cont = 3'd3;
        end else if (b[7:2] == LEAD5_TAG) begin
            info.cont = 3'd4;
        end else if (b[7:1] == LEAD6_TAG) begin
            info.cont = 3'd5;
        end else begin
            info.bad = 1'b1;
        end
        return info;
    endfunction

endpackage

>>> rtl/utf8v_in_reg.sv
module utf8v_in_reg
    import utf8v_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    input  logic     i_advance,
    output logic     o_held_valid,
    output t_in_item o_held_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     load;

    assign o_in_stall   = r_valid && !i_advance;
    assign load         = i_in_valid && !o_in_stall;
    assign n_valid      = load ? 1'b1 : (i_advance ? 1'b0 : r_valid);
    assign o_held_valid = r_valid;
    assign o_held_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_in_item;
        end
    end

endmodule

>>> rtl/utf8v_core.sv
module utf8v_core
    import utf8v_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [2:0]             r_cont_left, n_cont_left;
    logic [OFFSET_BITS-1:0] r_seq_start, n_seq_start;
    logic [7:0]             r_lead, n_lead;
    logic [7:0]             r_follow, n_follow;
    logic                   r_follow_pend, n_follow_pend;
    logic                   r_err, n_err;
    logic                   fail;
    logic [REPORT_BITS-1:0] rep_offset;
    t_lead_info             cls;

    assign cls = lead_class(i_item.data_byte);

    always_comb begin
        n_pos         = r_pos;
        n_cont_left   = r_cont_left;
        n_seq_start   = r_seq_start;
        n_lead        = r_lead;
        n_follow      = r_follow;
        n_follow_pend = r_follow_pend;
        n_err         = r_err;
        if (r_follow_pend) begin
            n_follow      = i_item.data_byte;
            n_follow_pend = 1'b0;
        end
        if (!r_err) begin
            if (r_cont_left == 3'd0) begin
                if (cls.bad || cls.cont != 3'd0) begin
                    n_seq_start   = r_pos;
                    n_lead        = i_item.data_byte;
                    n_follow      = 8'h00;
                    n_follow_pend = 1'b1;
                    if (cls.bad) begin
                        n_err = 1'b1;
                    end else begin
                        n_cont_left = cls.cont;
                    end
                end
            end else if (i_item.data_byte >= CONT_LO && i_item.data_byte <= CONT_HI) begin
                n_cont_left = r_cont_left - 3'd1;
            end else begin
                n_err = 1'b1;
            end
        end
        if (r_pos != {OFFSET_BITS{1'b1}}) begin
            n_pos = r_pos + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
        end
    end

    assign fail = n_err || (n_cont_left != 3'd0);

    generate
        if (OFFSET_BITS > REPORT_BITS) begin : g_sat
            assign rep_offset = (|n_seq_start[OFFSET_BITS-1:REPORT_BITS]) ?
                                {REPORT_BITS{1'b1}} : n_seq_start[REPORT_BITS-1:0];
        end else begin : g_ext
            assign rep_offset = REPORT_BITS'(n_seq_start);
        end
    endgenerate

    always_comb begin
        if (fail) begin
            o_result.text_valid   = 1'b0;
            o_result.error_offset = rep_offset;
            o_result.error_lead   = n_lead;
            o_result.error_follow = n_follow_pend ? 8'h00 : n_follow;
        end else begin
            o_result = '{text_valid: 1'b1, error_offset: '0,
                         error_lead: 8'h00, error_follow: 8'h00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_item.last_byte)) begin
            r_pos         <= '0;
            r_cont_left   <= 3'd0;
            r_seq_start   <= '0;
            r_lead        <= 8'h00;
            r_follow      <= 8'h00;
            r_follow_pend <= 1'b0;
            r_err         <= 1'b0;
        end else if (i_advance) begin
            r_pos         <= n_pos;
            r_cont_left   <= n_cont_left;
            r_seq_start   <= n_seq_start;
            r_lead        <= n_lead;
            r_follow      <= n_follow;
            r_follow_pend <= n_follow_pend;
            r_err         <= n_err;
        end
    end

endmodule

>>> rtl/utf8v_out_reg.sv
module utf8v_out_reg
    import utf8v_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_result,
    output logic      o_full_blocked,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    assign o_full_blocked = r_valid && i_out_stall;
    assign n_valid        = i_load ? 1'b1 : (r_valid && i_out_stall);
    assign o_out_valid    = r_valid;
    assign o_out_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_result;
        end
    end

endmodule

>>> rtl/utf8_stream_validator.sv
// Channel | Direction | Handshake                 | Payload
// in      | sink      | i_in_valid / o_in_stall   | i_in_item  (data_byte, last_byte)
// out     | source    | o_out_valid / i_out_stall | o_out_item (text_valid, error_*)
//
// One item per cycle sustained unless a final item waits; an item is checked from the input register.
// A result is computed from its final item in the input register and leaves
// through the result register.
// Synchronous active-low reset clears all stream state; state also clears after a final item.
// Only a final item waits on a full, stalled result register; other items keep flowing.
module utf8_stream_validator
    import utf8v_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      held_valid;
    t_in_item  held_item;
    logic      advance;
    logic      out_blocked;
    t_out_item result;

    assign advance = held_valid && !(held_item.last_byte && out_blocked);

    utf8v_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_advance    (advance),
        .o_held_valid (held_valid),
        .o_held_item  (held_item)
    );

    utf8v_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (held_item),
        .o_result  (result)
    );

    utf8v_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (advance && held_item.last_byte),
        .i_result       (result),
        .o_full_blocked (out_blocked),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_item     (o_out_item)
    );

endmodule

>>> rtl/utf8v_checker.sv
module utf8v_checker
    import utf8v_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
        else $error("stalled input item changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result changed");

    a_valid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.text_valid |->
            o_out_item.error_offset == '0 && o_out_item.error_lead == 8'h00 &&
            o_out_item.error_follow == 8'h00)
        else $error("valid result carries error fields");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

endmodule

bind utf8_stream_validator utf8v_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
